[hw/rtl/wmr_pkg.sv]
// Package with the shared constants, types and ring index helpers of the windowed max rise block.
package wmr_pkg;

  localparam int MAX_WINDOW = 128;
  localparam int VALUE_BITS = 30;
  localparam int PRICE_W    = 30;
  localparam int PROFIT_W   = 30;
  localparam int WIN_W      = 8;
  localparam int DAY_W      = 16;
  localparam int DEQ_DEPTH  = MAX_WINDOW + 1;
  localparam int IDX_W      = $clog2(DEQ_DEPTH);
  localparam int FILL_W     = $clog2(DEQ_DEPTH + 1);
  localparam int ENTRY_W    = VALUE_BITS + DAY_W;

  typedef enum logic [5:0] {
    S_IDLE    = 6'b000001,
    S_EXP_RD  = 6'b000010,
    S_EXP_CHK = 6'b000100,
    S_POP_RD  = 6'b001000,
    S_POP_CHK = 6'b010000,
    S_PUSH    = 6'b100000
  } state_e;

  typedef struct packed {
    logic load;
    logic rd_head;
    logic rd_last;
    logic drop_head;
    logic rise;
    logic drop_tail;
    logic push;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic fill_zero;
    logic fill_full;
    logic expired;
    logic keep;
  } status_t;

  function automatic logic [IDX_W-1:0] ring_next(input logic [IDX_W-1:0] i);
    ring_next = (i == IDX_W'(DEQ_DEPTH - 1)) ? '0 : i + IDX_W'(1);
  endfunction

  function automatic logic [IDX_W-1:0] ring_prev(input logic [IDX_W-1:0] i);
    ring_prev = (i == '0) ? IDX_W'(DEQ_DEPTH - 1) : i - IDX_W'(1);
  endfunction

endpackage

[hw/rtl/wmr_ram.sv]
// Generic single write port RAM with one registered read port.
module wmr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                    clk_i,
  input  logic                                    we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                        wdata_i,
  input  logic                                    re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                        rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[hw/rtl/wmr_datapath.sv]
// Datapath of the windowed max rise block: deque pointers, deque RAM, running best and result register.
module wmr_datapath
  import wmr_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cmd_t                cmd_i,
  output status_t             status_o,
  input  logic [PRICE_W-1:0]  price_i,
  input  logic                series_start_i,
  input  logic                cfg_valid_i,
  input  logic [WIN_W-1:0]    cfg_data_i,
  output logic [PROFIT_W-1:0] best_profit_o
);

  logic [VALUE_BITS-1:0] price_q;
  logic [IDX_W-1:0]      head_q, head_d;
  logic [IDX_W-1:0]      tail_q, tail_d;
  logic [FILL_W-1:0]     fill_q, fill_d;
  logic [DAY_W-1:0]      day_q, day_d;
  logic [VALUE_BITS-1:0] best_q, best_d;
  logic [WIN_W-1:0]      win_q;
  logic [PROFIT_W-1:0]   out_q;

  logic [ENTRY_W-1:0]    rdata;
  logic [VALUE_BITS-1:0] rd_value;
  logic [DAY_W-1:0]      rd_day;
  logic [DAY_W-1:0]      win_ext;
  logic [DAY_W-1:0]      k_eff;
  logic [DAY_W-1:0]      age;
  logic [VALUE_BITS-1:0] diff;
  logic [IDX_W-1:0]      raddr;
  logic                  we;

  assign rd_value = rdata[ENTRY_W-1:DAY_W];
  assign rd_day   = rdata[DAY_W-1:0];

  always_comb begin
    win_ext = DAY_W'(win_q);
    if (win_ext == '0) begin
      k_eff = DAY_W'(1);
    end else if (win_ext > DAY_W'(MAX_WINDOW)) begin
      k_eff = DAY_W'(MAX_WINDOW);
    end else begin
      k_eff = win_ext;
    end
  end

  assign age  = day_q - rd_day;
  assign diff = price_q - rd_value;

  assign status_o.fill_zero = (fill_q == '0);
  assign status_o.fill_full = (fill_q == FILL_W'(DEQ_DEPTH));
  assign status_o.expired   = (age > k_eff);
  assign status_o.keep      = (rd_value < price_q);

  assign raddr = cmd_i.rd_last ? ring_prev(tail_q) : head_q;
  assign we    = cmd_i.push && !status_o.fill_full;

  always_comb begin
    head_d = head_q;
    tail_d = tail_q;
    fill_d = fill_q;
    day_d  = day_q;
    best_d = best_q;
    if (cmd_i.load && series_start_i) begin
      head_d = '0;
      tail_d = '0;
      fill_d = '0;
      day_d  = '0;
      best_d = '0;
    end
    if (cmd_i.drop_head) begin
      head_d = ring_next(head_q);
      fill_d = fill_q - FILL_W'(1);
    end
    if (cmd_i.rise && (price_q > rd_value) && (diff > best_q)) begin
      best_d = diff;
    end
    if (cmd_i.drop_tail) begin
      tail_d = ring_prev(tail_q);
      fill_d = fill_q - FILL_W'(1);
    end
    if (we) begin
      tail_d = ring_next(tail_q);
      fill_d = fill_q + FILL_W'(1);
    end
    if (cmd_i.emit) begin
      day_d = day_q + DAY_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      tail_q <= '0;
      fill_q <= '0;
      day_q  <= '0;
      best_q <= '0;
      win_q  <= WIN_W'(1);
    end else begin
      head_q <= head_d;
      tail_q <= tail_d;
      fill_q <= fill_d;
      day_q  <= day_d;
      best_q <= best_d;
      if (cfg_valid_i) begin
        win_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      price_q <= VALUE_BITS'(price_i);
    end
    if (cmd_i.emit) begin
      out_q <= PROFIT_W'(best_q);
    end
  end

  wmr_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(DEQ_DEPTH)
  ) u_deque_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(tail_q),
    .wdata_i({price_q, day_q}),
    .re_i   (cmd_i.rd_head || cmd_i.rd_last),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  assign best_profit_o = out_q;

endmodule

[hw/rtl/wmr_ctrl.sv]
// Controller state machine of the windowed max rise block.
module wmr_ctrl
  import wmr_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_stall_o,
  output logic    out_valid_o,
  input  logic    out_stall_i,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_EXP_RD;
        end
      end
      S_EXP_RD: begin
        if (status_i.fill_zero) begin
          state_d = S_PUSH;
        end else begin
          cmd_o.rd_head = 1'b1;
          state_d       = S_EXP_CHK;
        end
      end
      S_EXP_CHK: begin
        if (status_i.expired) begin
          cmd_o.drop_head = 1'b1;
          state_d         = S_EXP_RD;
        end else begin
          cmd_o.rise = 1'b1;
          state_d    = S_POP_RD;
        end
      end
      S_POP_RD: begin
        if (status_i.fill_zero) begin
          state_d = S_PUSH;
        end else begin
          cmd_o.rd_last = 1'b1;
          state_d       = S_POP_CHK;
        end
      end
      S_POP_CHK: begin
        if (status_i.keep) begin
          state_d = S_PUSH;
        end else begin
          cmd_o.drop_tail = 1'b1;
          state_d         = S_POP_RD;
        end
      end
      S_PUSH: begin
        if (out_free) begin
          cmd_o.push = 1'b1;
          cmd_o.emit = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_o.emit) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

[hw/rtl/windowed_max_rise_top.sv]
// Top level of the windowed max rise block: best rise of a value stream within a day window.
//
//   channel  direction  handshake              payload
//   in       input      in_valid_i/in_stall_o   price_i, series_start_i
//   out      output     out_valid_o/out_stall_i best_profit_o
//   cfg      input      cfg_valid_i/cfg_ready_o cfg_data_i (window_days)
//
// After acceptance a word drops expired deque entries at the head (S_EXP_RD, S_EXP_CHK),
// then pops tail entries not below its value (S_POP_RD, S_POP_CHK), each read on the
// single RAM read port, and ends in S_PUSH; an empty deque goes straight to S_PUSH.
// Reset needs no clearing pass. A new word is accepted while the previous result waits
// in the output register; a stalled output holds the block before push.
module windowed_max_rise_top
  import wmr_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [PRICE_W-1:0]  price_i,
  input  logic                series_start_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [PROFIT_W-1:0] best_profit_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [WIN_W-1:0]    cfg_data_i
);

  cmd_t    cmd;
  status_t status;

  assign cfg_ready_o = 1'b1;

  wmr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  wmr_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (status),
    .price_i       (price_i),
    .series_start_i(series_start_i),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_data_i    (cfg_data_i),
    .best_profit_o (best_profit_o)
  );

endmodule
